// ===== rtl/mft_pkg.sv =====
// Shared types, codes and frame constants of the Manchester frame transmitter.
package mft_pkg;

  localparam int unsigned SLOT_W = 8;
  localparam int unsigned PREAMBLE_SLOTS = 32;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } mft_op_e;

  localparam logic [2:0] CMD_ECO       = 3'd0;
  localparam logic [2:0] CMD_COMFORT   = 3'd1;
  localparam logic [2:0] CMD_FROST     = 3'd2;
  localparam logic [2:0] CMD_STOP      = 3'd3;
  localparam logic [2:0] CMD_CONFIGURE = 3'd4;

  localparam logic [7:0] ADDR_BYTE0     = 8'h07;
  localparam logic [7:0] ADDR_BYTE1     = 8'h04;
  localparam logic [7:0] ADDR_DEV_BASE  = 8'hF0;
  localparam logic [7:0] ADDR_BYTE3     = 8'h00;
  localparam logic [7:0] ADDR_BYTE4     = 8'h02;
  localparam logic [7:0] CMD_HEAD_HEAT  = 8'h20;
  localparam logic [7:0] CMD_HEAD_CONF  = 8'h05;
  localparam logic [7:0] CMD_TAIL_ECO   = 8'h8B;
  localparam logic [7:0] CMD_TAIL_COMF  = 8'h88;
  localparam logic [7:0] CMD_TAIL_FROST = 8'hCC;
  localparam logic [7:0] CMD_TAIL_CONF  = 8'h01;

  typedef struct packed {
    logic              sending;
    logic [SLOT_W-1:0] slot;
    logic [3:0]        device;
    logic [2:0]        command;
    logic [7:0]        sum;
  } mft_state_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic frame_end;
  } mft_result_t;

  // Address/command byte k of the frame (the checksum byte is not covered).
  function automatic logic [7:0] payload_byte(input logic [2:0] k, input logic [3:0] dev,
                                              input logic [2:0] cmd);
    logic [7:0] val;
    case (k)
      3'd0: val = ADDR_BYTE0;
      3'd1: val = ADDR_BYTE1;
      3'd2: val = ADDR_DEV_BASE + {4'h0, dev};
      3'd3: val = ADDR_BYTE3;
      3'd4: val = ADDR_BYTE4;
      3'd5: val = (cmd == CMD_CONFIGURE) ? CMD_HEAD_CONF : CMD_HEAD_HEAT;
      default: begin
        case (cmd)
          CMD_ECO:       val = CMD_TAIL_ECO;
          CMD_COMFORT:   val = CMD_TAIL_COMF;
          CMD_CONFIGURE: val = CMD_TAIL_CONF;
          default:       val = CMD_TAIL_FROST;
        endcase
      end
    endcase
    return val;
  endfunction

endpackage

// ===== rtl/mft_if.sv =====
// Valid/ready channel interfaces for the input items and the slot results.
interface mft_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [3:0] device_id;
  logic [2:0] command;

  modport source (output valid, output operation, output device_id, output command,
                  input ready);
  modport sink (input valid, input operation, input device_id, input command,
                output ready);
endinterface

interface mft_out_if;
  logic valid;
  logic ready;
  logic line_level;
  logic busy_res;
  logic frame_end;

  modport source (output valid, output line_level, output busy_res, output frame_end,
                  input ready);
  modport sink (input valid, input line_level, input busy_res, input frame_end,
                output ready);
endinterface

// ===== rtl/manchester_frame_transmitter_unit.sv =====
// Top level of the Manchester frame transmitter: state and result registers.
//
// Usage:
//   in_i  (sink) carries one transaction per slot event. operation = 1 starts
//         a frame and latches device_id and command; operation = 0 is a tick
//         for one 210 us slot. Start while a frame runs restarts it.
//   out_o (source) returns exactly one result per input transaction:
//         line_level for the slot, busy_res while a frame is active and
//         frame_end on the last slot of the frame.
// Latency: the result of a transaction is valid the cycle after it is taken.
// Throughput: one transaction per cycle unless out_o stalls; the slot counter
//   update and level pick are one short combinational pass between the frame
//   state register and the result register.
// Reset: rst_ni clears the frame state (idle) and empties the result register.
// Stall: while a result waits and out_o.ready is low, in_i.ready drops; a
//   new transaction is taken in the same cycle the waiting result leaves.
// Frame length: 164 + 5 * LONG_PULSE_SLOTS ticks, 32 fewer for commands
//   that carry no command bytes.
module manchester_frame_transmitter_unit
  import mft_pkg::*;
#(
  parameter int unsigned LONG_PULSE_SLOTS = 3
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  mft_in_if.sink           in_i,
  mft_out_if.source        out_o
);

  mft_state_t  state_q, state_d;
  mft_result_t res_q, res_d;
  logic        out_valid_q;
  logic        in_take;

  // result register frees up when empty or when its transaction completes
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_take    = in_i.valid && in_i.ready;

  mft_slot_gen #(
    .LONG_PULSE_SLOTS(LONG_PULSE_SLOTS)
  ) u_slot_gen (
    .st_i        (state_q),
    .operation_i (in_i.operation),
    .device_id_i (in_i.device_id),
    .command_i   (in_i.command),
    .st_o        (state_d),
    .res_o       (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.line_level = res_q.line_level;
  assign out_o.busy_res   = res_q.busy_res;
  assign out_o.frame_end  = res_q.frame_end;

  // a start transaction arms the frame at slot zero
  a_start_arms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_take && in_i.operation == OP_START) |=> (state_q.sending && state_q.slot == '0))
    else $error("start did not arm the frame");

  // the last slot of a frame leaves the block idle
  a_end_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_take && in_i.operation == OP_TICK && res_d.frame_end) |=> !state_q.sending)
    else $error("frame did not end after its last slot");

  // idle results keep the line low and never flag an end
  a_idle_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_q.busy_res) |-> (!res_q.line_level && !res_q.frame_end))
    else $error("line driven while idle");

endmodule

// ===== rtl/mft_slot_gen.sv =====
// Per-slot level selection and frame state update for one transaction.
module mft_slot_gen
  import mft_pkg::*;
#(
  parameter int unsigned LONG_PULSE_SLOTS = 3
) (
  input  mft_state_t  st_i,
  input  logic        operation_i,
  input  logic [3:0]  device_id_i,
  input  logic [2:0]  command_i,
  output mft_state_t  st_o,
  output mft_result_t res_o
);

  localparam int unsigned SyncG     = 2 * LONG_PULSE_SLOTS + 2;
  localparam int unsigned DataStart = PREAMBLE_SLOTS + 2 * SyncG;
  localparam int unsigned Total8    = DataStart + 16 * 8 + LONG_PULSE_SLOTS;
  localparam int unsigned Total6    = DataStart + 16 * 6 + LONG_PULSE_SLOTS;

  localparam logic [SLOT_W-1:0] PRE_END    = SLOT_W'(PREAMBLE_SLOTS);
  localparam logic [SLOT_W-1:0] SYNC_G     = SLOT_W'(SyncG);
  localparam logic [SLOT_W-1:0] DATA_START = SLOT_W'(DataStart);
  localparam logic [SLOT_W-1:0] DATA_END8  = SLOT_W'(DataStart + 16 * 8);
  localparam logic [SLOT_W-1:0] DATA_END6  = SLOT_W'(DataStart + 16 * 6);
  localparam logic [SLOT_W-1:0] LAST8      = SLOT_W'(Total8 - 1);
  localparam logic [SLOT_W-1:0] LAST6      = SLOT_W'(Total6 - 1);
  localparam logic [SLOT_W-1:0] LP         = SLOT_W'(LONG_PULSE_SLOTS);
  localparam logic [SLOT_W-1:0] LP2        = SLOT_W'(2 * LONG_PULSE_SLOTS);

  logic [SLOT_W-1:0] s, p, g, d, data_end, last_slot;
  logic              long_cmd, is_sum, bit_val, sync_lvl;
  logic [2:0]        k, b, last_k;
  logic [7:0]        pb, cur_byte;
  logic              level;

  always_comb begin
    s         = st_i.slot;
    long_cmd  = (st_i.command <= CMD_CONFIGURE);
    data_end  = long_cmd ? DATA_END8 : DATA_END6;
    last_slot = long_cmd ? LAST8 : LAST6;
    last_k    = long_cmd ? 3'd7 : 3'd5;
    // sync offset stays below two groups, so one conditional subtract folds it
    p = s - PRE_END;
    g = (p >= SYNC_G) ? (p - SYNC_G) : p;
    if (g < LP)        sync_lvl = 1'b1;
    else if (g < LP2)  sync_lvl = 1'b0;
    else if (g == LP2) sync_lvl = 1'b1;
    else               sync_lvl = 1'b0;
    d        = s - DATA_START;
    k        = d[6:4];
    b        = d[3:1];
    is_sum   = (k == last_k);
    pb       = payload_byte(k, st_i.device, st_i.command);
    cur_byte = is_sum ? (8'h00 - st_i.sum) : pb;
    bit_val  = cur_byte[3'd7 - b];

    if (s < PRE_END)         level = ~s[0];
    else if (s < DATA_START) level = sync_lvl;
    else if (s < data_end)   level = d[0] ? bit_val : ~bit_val;
    else                     level = 1'b0;
  end

  always_comb begin
    st_o  = st_i;
    res_o = '0;
    if (operation_i == OP_START) begin
      st_o.sending = 1'b1;
      st_o.slot    = '0;
      st_o.device  = device_id_i;
      st_o.command = command_i;
      st_o.sum     = '0;
      res_o.busy_res = 1'b1;
    end else if (st_i.sending) begin
      res_o.busy_res   = 1'b1;
      res_o.line_level = level;
      if ((s >= DATA_START) && (s < data_end) && !is_sum && (d[3:0] == 4'd0)) begin
        st_o.sum = st_i.sum + pb;
      end
      if (s >= last_slot) begin
        res_o.frame_end = 1'b1;
        st_o.sending    = 1'b0;
        st_o.slot       = '0;
      end else begin
        st_o.slot = s + 1'b1;
      end
    end
  end

endmodule

// ===== verif/manchester_frame_transmitter_unit_checker.sv =====
// Checker for the Manchester frame transmitter: slot-level predictor and result compare.
`timescale 1ns / 100ps
module manchester_frame_transmitter_unit_checker
  import mft_pkg::*;
#(
  parameter int unsigned LONG_PULSE_SLOTS = 3
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mft_in_if           in_mon,
  mft_out_if          out_mon,
  output int unsigned mismatch_count_o,
  output int unsigned pending_count_o
);

  localparam int unsigned SYNC_SLOTS = 2 * LONG_PULSE_SLOTS + 2;
  localparam int unsigned DATA_SLOT0 = PREAMBLE_SLOTS + 2 * SYNC_SLOTS;

  // Shadow frame state
  logic              tx_active;
  logic [SLOT_W-1:0] tx_slot;
  logic [3:0]        tx_device;
  logic [2:0]        tx_command;
  logic [7:0]        tx_sum;

  mft_result_t       expected_slots[$];
  int unsigned       result_count;

  // Address and command bytes; the checksum byte is worked out from tx_sum.
  function automatic logic [7:0] frame_byte(input int unsigned k);
    case (k)
      0: return ADDR_BYTE0;
      1: return ADDR_BYTE1;
      2: return ADDR_DEV_BASE + {4'h0, tx_device};
      3: return ADDR_BYTE3;
      4: return ADDR_BYTE4;
      5: return (tx_command == CMD_CONFIGURE) ? CMD_HEAD_CONF : CMD_HEAD_HEAT;
      default: begin
        case (tx_command)
          CMD_ECO:       return CMD_TAIL_ECO;
          CMD_COMFORT:   return CMD_TAIL_COMF;
          CMD_CONFIGURE: return CMD_TAIL_CONF;
          default:       return CMD_TAIL_FROST;
        endcase
      end
    endcase
  endfunction

  // Level, busy and end flag for one transaction; advances the shadow state.
  function automatic mft_result_t next_slot_result(input mft_op_e op, input logic [3:0] dev,
                                                   input logic [2:0] cmd);
    mft_result_t res;
    int unsigned s, nbytes, total, g, d;
    logic [7:0]  data_byte;
    logic        data_bit;
    res = '0;
    if (op == OP_START) begin
      tx_device      = dev;
      tx_command     = cmd;
      tx_active      = 1'b1;
      tx_slot        = '0;
      tx_sum         = '0;
      res.busy_res   = 1'b1;
    end else if (tx_active) begin
      s            = tx_slot;
      nbytes       = (tx_command <= CMD_CONFIGURE) ? 8 : 6;
      total        = DATA_SLOT0 + 16 * nbytes + LONG_PULSE_SLOTS;
      res.busy_res = 1'b1;
      if (s < PREAMBLE_SLOTS) begin
        res.line_level = (s % 2 == 0);
      end else if (s < DATA_SLOT0) begin
        g = (s - PREAMBLE_SLOTS) % SYNC_SLOTS;
        res.line_level = (g < LONG_PULSE_SLOTS) || (g == 2 * LONG_PULSE_SLOTS);
      end else if (s < DATA_SLOT0 + 16 * nbytes) begin
        d = s - DATA_SLOT0;
        if (d / 16 + 1 < nbytes) begin
          data_byte = frame_byte(d / 16);
          if (d % 16 == 0) tx_sum = tx_sum + data_byte;
        end else begin
          data_byte = 8'h00 - tx_sum;
        end
        data_bit       = data_byte[7 - (d / 2) % 8];
        res.line_level = (d % 2 == 1) ? data_bit : ~data_bit;
      end
      if (s + 1 >= total) begin
        res.frame_end = 1'b1;
        tx_active     = 1'b0;
        tx_slot       = '0;
      end else begin
        tx_slot = SLOT_W'(s + 1);
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] result %0d: %s", $time, result_count, msg);
    mismatch_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    mft_result_t want;
    if (!rst_ni) begin
      tx_active    = 1'b0;
      tx_slot      = '0;
      tx_device    = '0;
      tx_command   = '0;
      tx_sum       = '0;
      result_count = 0;
      expected_slots.delete();
    end else begin
      // Outputs first: a result always belongs to an earlier input transaction.
      if (out_mon.valid && out_mon.ready) begin
        if (expected_slots.size() == 0) begin
          report_mismatch("result transaction with nothing expected");
        end else begin
          want = expected_slots.pop_front();
          if (out_mon.line_level !== want.line_level)
            report_mismatch($sformatf("line_level %b, expected %b",
                                      out_mon.line_level, want.line_level));
          if (out_mon.busy_res !== want.busy_res)
            report_mismatch($sformatf("busy_res %b, expected %b",
                                      out_mon.busy_res, want.busy_res));
          if (out_mon.frame_end !== want.frame_end)
            report_mismatch($sformatf("frame_end %b, expected %b",
                                      out_mon.frame_end, want.frame_end));
        end
        result_count++;
      end
      if (in_mon.valid && in_mon.ready)
        expected_slots.push_back(next_slot_result(mft_op_e'(in_mon.operation),
                                                  in_mon.device_id, in_mon.command));
    end
    pending_count_o = expected_slots.size();
  end

endmodule

// ===== verif/manchester_frame_transmitter_unit_tb.sv =====
// Testbench top for the Manchester frame transmitter: stimulus, handshake pacing and verdict.
`timescale 1ns / 100ps
module manchester_frame_transmitter_unit_tb;
  import mft_pkg::*;

  localparam int unsigned LONG_PULSE_SLOTS = 3;
  // Ticks from the first slot to frame_end, with and without command bytes.
  localparam int unsigned FULL_FRAME_TICKS  = 164 + 5 * LONG_PULSE_SLOTS;
  localparam int unsigned SHORT_FRAME_TICKS = FULL_FRAME_TICKS - 32;
  // Broken frames may run into the data bytes before the next start cuts them.
  localparam int unsigned BROKEN_MAX_TICKS  = 80;
  // ~950 transactions at worst pacing stay well below this.
  localparam int unsigned CYCLE_LIMIT       = 200000;
  // The result is registered the cycle after the transaction; the drain adds spare cycles.
  localparam int unsigned DRAIN_CYCLES      = 8;
  localparam int unsigned MAX_GAP           = 12;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycle_count    = 0;
  int unsigned mismatch_count;
  int unsigned pending_count;

  mft_in_if  in_bus ();
  mft_out_if out_bus ();

  manchester_frame_transmitter_unit #(
    .LONG_PULSE_SLOTS(LONG_PULSE_SLOTS)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  manchester_frame_transmitter_unit_checker #(
    .LONG_PULSE_SLOTS(LONG_PULSE_SLOTS)
  ) i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_mon          (in_bus),
    .out_mon         (out_bus),
    .mismatch_count_o(mismatch_count),
    .pending_count_o (pending_count)
  );

  always #2 clk_i = ~clk_i;

  // Watchdog: a hung handshake or a missing result ends up here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side back-pressure, redrawn every falling edge.
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_bus.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Pacing phases: 0 free-running, 1 sparse sender, 2 stalling receiver, 3 both lightly.
  task automatic set_idling(input int unsigned phase);
    case (phase % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
      default: begin send_idle_pct = 18; recv_stall_pct = 18; end
    endcase
  endtask

  // One input transaction: optional idle gap, then hold valid until taken.
  // Valid is only written at falling edges and at most once per edge, so a
  // back-to-back transaction keeps valid high without a glitch.
  task automatic send_item(input mft_op_e op, input logic [3:0] dev, input logic [2:0] cmd);
    int unsigned gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    repeat (gap) begin
      @(negedge clk_i);
      in_bus.valid = 1'b0;
    end
    @(negedge clk_i);
    in_bus.valid     = 1'b1;
    in_bus.operation = op;
    in_bus.device_id = dev;
    in_bus.command   = cmd;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
  endtask

  // Ticks carry junk in device_id/command; the block must ignore it.
  task automatic send_ticks(input int unsigned n);
    repeat (n) send_item(OP_TICK, 4'($urandom), 3'($urandom));
  endtask

  initial begin
    logic [2:0]  cmd;

    in_bus.valid     = 1'b0;
    in_bus.operation = OP_TICK;
    in_bus.device_id = '0;
    in_bus.command   = '0;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // ---- Directed part ----
    set_idling(0);
    send_ticks(2);                              // ticks while idle: all-zero result
    send_item(OP_START, 4'hF, 3'b111);          // top device id, no command bytes
    send_ticks(3);
    send_item(OP_START, 4'h0, CMD_ECO);         // restart in the middle of a frame
    send_ticks(2);
    send_item(OP_START, 4'h5, CMD_COMFORT);
    send_item(OP_START, 4'hA, CMD_FROST);       // back-to-back starts
    send_item(OP_START, 4'h3, CMD_STOP);
    send_ticks(1);
    send_item(OP_START, 4'hC, CMD_CONFIGURE);
    send_ticks(1);
    send_item(OP_START, 4'h9, 3'b101);
    send_ticks(1);
    send_item(OP_START, 4'h6, 3'b110);
    send_ticks(2);

    // ---- Random part ----
    // One complete frame per distinct command byte pair, plus one frame without
    // command bytes. Some frames are preceded by a broken one that is cut short
    // by the next start, often inside its data bytes.
    for (int unsigned j = 0; j < 5; j++) begin
      set_idling(j);
      if ($urandom_range(3) == 0) begin
        send_item(OP_START, 4'($urandom), 3'($urandom));
        send_ticks($urandom_range(1, BROKEN_MAX_TICKS));
      end
      case (j)
        0: cmd = CMD_ECO;
        1: cmd = CMD_COMFORT;
        2: cmd = ($urandom_range(1) == 0) ? CMD_FROST : CMD_STOP;
        3: cmd = CMD_CONFIGURE;
        default: cmd = 3'($urandom_range(7, 5));
      endcase
      send_item(OP_START, 4'($urandom), cmd);
      send_ticks((cmd <= CMD_CONFIGURE) ? FULL_FRAME_TICKS : SHORT_FRAME_TICKS);
      send_ticks($urandom_range(0, 3));         // idle ticks after frame_end
    end

    @(negedge clk_i);
    in_bus.valid = 1'b0;

    // Wait for every outstanding result transaction, then a short drain.
    while (pending_count != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
